// ===== src/md5sh_pkg.sv =====
// Shared types, constants and round tables of the MD5 stream hasher.
package md5sh_pkg;

  // Initial chaining words A, B, C, D.
  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  // First byte of the padding.
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Byte position at which the length field starts in the last block.
  localparam logic [5:0] LEN_POS = 6'd56;

  // What the block under compression is made of.
  localparam logic [1:0] KIND_DATA    = 2'd0;  // 64 message bytes
  localparam logic [1:0] KIND_PAD     = 2'd1;  // tail bytes, pad byte, zeros
  localparam logic [1:0] KIND_PAD_LEN = 2'd2;  // tail bytes, pad byte, zeros, length
  localparam logic [1:0] KIND_LEN     = 2'd3;  // zeros and length

  // Per-round additive constants.
  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts, indexed by {round group, round index modulo four}.
  localparam logic [4:0] ROUND_ROT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       byte_wr;      // store the input byte and bump the count
    logic       start;        // load the working words from the chain
    logic       round_en;     // run one compression round
    logic [5:0] round_idx;    // which round
    logic [1:0] kind;         // block make-up for the word assembly
    logic       fold;         // add the working words into the chain
    logic       digest_load;  // capture the digest and re-initialize
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [5:0] cnt_low;      // message byte count modulo 64
    logic       out_free;     // output register empty
  } sts_t;

endpackage

// ===== src/md5sh_if.sv =====
// Word channels of the MD5 stream hasher: message bytes in, digest halves out.
interface md5sh_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source (output valid, output data_byte, output byte_valid,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input byte_valid,
                  input end_of_message, output ready);
endinterface

interface md5sh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_half;
  logic        half_index;
  logic        last_result;

  modport source (output valid, output digest_half, output half_index,
                  output last_result, input ready);
  modport sink   (input valid, input digest_half, input half_index,
                  input last_result, output ready);
endinterface

// ===== src/md5sh_ctrl.sv =====
// Controller state machine of the MD5 stream hasher.
module md5sh_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_byte_valid_i,
  input  logic          in_eom_i,
  output logic          in_ready_o,
  input  md5sh_pkg::sts_t sts_i,
  output md5sh_pkg::cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ROUND  = 2'd1;
  localparam logic [1:0] ST_FOLD   = 2'd2;
  localparam logic [1:0] ST_DIGEST = 2'd3;

  logic [1:0] state_q, state_d;
  logic [5:0] round_q, round_d;
  logic [1:0] kind_q, kind_d;
  logic       final_q, final_d;
  logic [5:0] new_low;

  assign new_low    = sts_i.cnt_low + {5'd0, in_byte_valid_i};
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    kind_d  = kind_q;
    final_d = final_q;

    cmd_o             = '0;
    cmd_o.round_idx   = round_q;
    cmd_o.kind        = kind_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.byte_wr = in_byte_valid_i;
          if (in_byte_valid_i && (new_low == 6'd0)) begin
            // This byte fills the block.
            kind_d      = md5sh_pkg::KIND_DATA;
            final_d     = in_eom_i;
            round_d     = 6'd0;
            cmd_o.start = 1'b1;
            state_d     = ST_ROUND;
          end else if (in_eom_i) begin
            kind_d      = (new_low < md5sh_pkg::LEN_POS) ? md5sh_pkg::KIND_PAD_LEN
                                                          : md5sh_pkg::KIND_PAD;
            final_d     = 1'b1;
            round_d     = 6'd0;
            cmd_o.start = 1'b1;
            state_d     = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        cmd_o.round_en = 1'b1;
        round_d        = round_q + 6'd1;
        if (round_q == 6'd63) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        round_d    = 6'd0;
        unique case (kind_q)
          md5sh_pkg::KIND_DATA: begin
            if (final_q) begin
              kind_d  = md5sh_pkg::KIND_PAD_LEN;
              state_d = ST_ROUND;
            end else begin
              state_d = ST_IDLE;
            end
          end
          md5sh_pkg::KIND_PAD: begin
            kind_d  = md5sh_pkg::KIND_LEN;
            state_d = ST_ROUND;
          end
          default: begin
            state_d = ST_DIGEST;
          end
        endcase
      end
      ST_DIGEST: begin
        if (sts_i.out_free) begin
          cmd_o.digest_load = 1'b1;
          final_d           = 1'b0;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      round_q <= 6'd0;
      kind_q  <= md5sh_pkg::KIND_DATA;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      kind_q  <= kind_d;
      final_q <= final_d;
    end
  end

endmodule

// ===== src/md5sh_datapath.sv =====
// Datapath of the MD5 stream hasher: block store, round unit, chain and output register.
module md5sh_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      data_byte_i,
  input  md5sh_pkg::cmd_t cmd_i,
  output md5sh_pkg::sts_t sts_o,
  md5sh_out_if.source     out_o
);

  function automatic logic [31:0] bswap(input logic [31:0] x);
    bswap = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  logic [31:0]  blk_q [16];
  logic [63:0]  cnt_q, cnt_d;
  logic [31:0]  chain_q [4];
  logic [31:0]  a_q, b_q, c_q, d_q;
  logic [127:0] dig_q;
  logic         out_valid_q, half_q;

  // Round logic.
  logic [5:0]  ri;
  logic [3:0]  i4, g;
  logic [31:0] f, w, stored, sum, rot, k;
  logic [4:0]  s;
  logic [63:0] rot2, len;
  logic [31:0] fa, fb, fc, fd;

  assign ri = cmd_i.round_idx;
  assign i4 = ri[3:0];
  assign k  = md5sh_pkg::ROUND_K[ri];
  assign s  = md5sh_pkg::ROUND_ROT[{ri[5:4], ri[1:0]}];

  always_comb begin
    unique case (ri[5:4])
      2'd0: begin
        f = (b_q & c_q) | (~b_q & d_q);
        g = i4;
      end
      2'd1: begin
        f = (b_q & d_q) | (c_q & ~d_q);
        g = i4 + {i4[1:0], 2'b00} + 4'd1;
      end
      2'd2: begin
        f = b_q ^ c_q ^ d_q;
        g = i4 + {i4[2:0], 1'b0} + 4'd5;
      end
      default: begin
        f = c_q ^ (b_q | ~d_q);
        g = {i4[0], 3'b000} - i4;
      end
    endcase
  end

  // Message word assembly: stored bytes, pad byte, zero fill and length
  // are merged lane by lane according to the block kind.
  assign stored = blk_q[g];
  assign len    = {cnt_q[60:0], 3'b000};

  always_comb begin
    logic [5:0] j;
    logic       keep, pad, has_len;
    w = '0;
    for (int lane = 0; lane < 4; lane++) begin
      j       = {g, 2'(lane)};
      keep    = (cmd_i.kind == md5sh_pkg::KIND_DATA) ||
                (((cmd_i.kind == md5sh_pkg::KIND_PAD) ||
                  (cmd_i.kind == md5sh_pkg::KIND_PAD_LEN)) && (j < cnt_q[5:0]));
      pad     = ((cmd_i.kind == md5sh_pkg::KIND_PAD) ||
                 (cmd_i.kind == md5sh_pkg::KIND_PAD_LEN)) && (j == cnt_q[5:0]);
      has_len = ((cmd_i.kind == md5sh_pkg::KIND_PAD_LEN) ||
                 (cmd_i.kind == md5sh_pkg::KIND_LEN)) && (j >= md5sh_pkg::LEN_POS);
      if (keep) begin
        w[8*lane +: 8] = stored[8*lane +: 8];
      end else if (pad) begin
        w[8*lane +: 8] = md5sh_pkg::PAD_BYTE;
      end else if (has_len) begin
        w[8*lane +: 8] = len[8*j[2:0] +: 8];
      end
    end
  end

  assign sum  = a_q + f + k + w;
  assign rot2 = {sum, sum} << s;
  assign rot  = rot2[63:32];

  assign fa = chain_q[0] + a_q;
  assign fb = chain_q[1] + b_q;
  assign fc = chain_q[2] + c_q;
  assign fd = chain_q[3] + d_q;

  assign cnt_d = cnt_q + 64'd1;

  // Block store: no reset, every byte that is read was written first.
  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_wr) begin
      blk_q[cnt_q[5:2]][8*cnt_q[1:0] +: 8] <= data_byte_i;
    end
  end

  // Working words.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
    end else if (cmd_i.fold) begin
      a_q <= fa;
      b_q <= fb;
      c_q <= fc;
      d_q <= fd;
    end else if (cmd_i.round_en) begin
      a_q <= d_q;
      d_q <= c_q;
      c_q <= b_q;
      b_q <= b_q + rot;
    end
  end

  // Chain words and byte count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q[0] <= md5sh_pkg::INIT_A;
      chain_q[1] <= md5sh_pkg::INIT_B;
      chain_q[2] <= md5sh_pkg::INIT_C;
      chain_q[3] <= md5sh_pkg::INIT_D;
      cnt_q      <= 64'd0;
    end else begin
      if (cmd_i.digest_load) begin
        chain_q[0] <= md5sh_pkg::INIT_A;
        chain_q[1] <= md5sh_pkg::INIT_B;
        chain_q[2] <= md5sh_pkg::INIT_C;
        chain_q[3] <= md5sh_pkg::INIT_D;
        cnt_q      <= 64'd0;
      end else begin
        if (cmd_i.fold) begin
          chain_q[0] <= fa;
          chain_q[1] <= fb;
          chain_q[2] <= fc;
          chain_q[3] <= fd;
        end
        if (cmd_i.byte_wr) begin
          cnt_q <= cnt_d;
        end
      end
    end
  end

  // Output register holding both digest halves.
  always_ff @(posedge clk_i) begin
    if (cmd_i.digest_load) begin
      dig_q <= {bswap(chain_q[0]), bswap(chain_q[1]),
                bswap(chain_q[2]), bswap(chain_q[3])};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      half_q      <= 1'b0;
    end else if (cmd_i.digest_load) begin
      out_valid_q <= 1'b1;
      half_q      <= 1'b0;
    end else if (out_valid_q && out_o.ready) begin
      if (half_q) begin
        out_valid_q <= 1'b0;
        half_q      <= 1'b0;
      end else begin
        half_q <= 1'b1;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.digest_half = half_q ? dig_q[63:0] : dig_q[127:64];
  assign out_o.half_index  = half_q;
  assign out_o.last_result = half_q;

  assign sts_o.cnt_low  = cnt_q[5:0];
  assign sts_o.out_free = !out_valid_q;

endmodule

// ===== src/md5_stream_hasher_top.sv =====
// Top level of the MD5 stream hasher: controller and datapath.
//
//   Channel   Dir   Fields                                   Word accepted when
//   in_i      in    data_byte, byte_valid, end_of_message    valid && ready
//   out_o     out   digest_half, half_index, last_result     valid && ready
//
// A byte that leaves its block incomplete only writes the block store and count; a byte
// that completes a block holds the input through the accept, 64 rounds at one per cycle,
// and a fold. An end-of-message word adds one or two padding blocks of 64 rounds and a
// fold each, then a digest register load, which waits while both halves of the previous
// digest drain. Reset loads the MD5 initial chain and clears the count; the block store
// needs no clearing. A stalled output holds up the digest load and, with it, the input.
module md5_stream_hasher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  md5sh_in_if.sink    in_i,
  md5sh_out_if.source out_o
);

  md5sh_pkg::cmd_t cmd;
  md5sh_pkg::sts_t sts;
  logic            in_ready;

  // The controller sequences byte capture, the compression rounds and padding.
  md5sh_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_i.valid),
    .in_byte_valid_i (in_i.byte_valid),
    .in_eom_i        (in_i.end_of_message),
    .in_ready_o      (in_ready),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  assign in_i.ready = in_ready;

  // The datapath holds the block store, chain, round unit and output register.
  md5sh_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_byte_i (in_i.data_byte),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_o       (out_o)
  );

endmodule
